// ===== rtl/pcbe_pkg.sv =====
// Shared constants, types and helpers for the phase coding bin embedder.
// No dependencies; every other file imports this package.
`default_nettype none

package pcbe_pkg;

    // Phase format: pi is 3072 units, 13-bit signed two's complement.
    localparam int unsigned PHASE_W      = 13;
    localparam int unsigned PI_UNITS     = 3072;
    localparam int unsigned TWO_PI_UNITS = 2 * PI_UNITS;

    // Configuration port.
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BIN   = 2'd1;
    localparam logic [CFG_W-1:0] FIRST_BIN_RST = 11'd23;
    localparam logic [CFG_W-1:0] END_BIN_RST   = 11'd186;

    // Parameter defaults and the widest values their ranges allow.
    localparam int unsigned FRAME_BINS_DEF = 1024;
    localparam int unsigned STEPS_DEF      = 12;
    localparam int unsigned POS_MAX_W      = 13;   // frame of up to 8192 bins
    localparam int unsigned CMP_W          = 14;   // bin compares, first_bin + count

    // Quotient of |phase| by the step: at most 4096 / 48 at the finest step.
    localparam int unsigned Q_CNT_W  = 7;
    localparam int unsigned RECIP_SH = 24;
    localparam int unsigned RECIP_W  = 25;

    // Wide working width for phase sums before wrapping.
    localparam int unsigned WORK_W = 16;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_QUANT,
        OP_TRACK
    } t_op;

    typedef struct packed {
        t_op                         op;
        logic signed [PHASE_W-1:0]   phase;
        logic                        data_bit;
        logic [Q_CNT_W-1:0]          quot;
        logic                        taken;
        logic                        last;
        logic [POS_MAX_W-1:0]        pos;
    } t_job;

    // One wrap step into [-pi, pi].
    function automatic logic signed [WORK_W-1:0] wrap_step(input logic signed [WORK_W-1:0] x);
        logic signed [WORK_W-1:0] r;
        r = x;
        if (x > $signed(WORK_W'(PI_UNITS))) begin
            r = x - $signed(WORK_W'(TWO_PI_UNITS));
        end else if (x < -$signed(WORK_W'(PI_UNITS))) begin
            r = x + $signed(WORK_W'(TWO_PI_UNITS));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pcbe_in_if.sv =====
// Input channel: one bin phase with the offered message bit.
// Depends on pcbe_pkg.
`default_nettype none

interface pcbe_in_if import pcbe_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [PHASE_W-1:0] phase_in;
    logic                      data_bit;
    logic                      data_valid;

    modport source (output valid, output phase_in, output data_bit, output data_valid,
                    input ready);
    modport sink   (input valid, input phase_in, input data_bit, input data_valid,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pcbe_out_if.sv =====
// Output channel: one processed bin phase with its flags.
// Depends on pcbe_pkg.
`default_nettype none

interface pcbe_out_if import pcbe_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [PHASE_W-1:0] phase_out;
    logic                      bit_taken;
    logic                      frame_end;

    modport source (output valid, output phase_out, output bit_taken, output frame_end,
                    input ready);
    modport sink   (input valid, input phase_out, input bit_taken, input frame_end,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/phase_coding_bin_embedder_unit.sv =====
// Top level of the phase coding bin embedder: front end, job queue, back end.
// Depends on pcbe_pkg, pcbe_in_if, pcbe_out_if, pcbe_front, pcbe_queue, pcbe_back.
//
// Takes one FFT bin phase (pi = 3072) per cycle unless the job queue is full, and
// returns one phase per bin in the same order. In the first frame, bins in
// [first_bin, end_bin) take a message bit each and are quantized to the step grid;
// a bin offered no valid bit ends the message. In later frames the encoded bins
// follow the previous modified phase plus the change of the original phase.
// Sustained rate is one bin per clock while the output is ready. From accept to
// output valid a bin passes the job queue, stage one (registered read of the two
// per-bin phase stores, one read and one write per bin each) and the output
// register. The stores need no clearing: every entry is written in the first frame
// before it is used. Write first_bin and end_bin only while no bin is in flight.
`default_nettype none

module phase_coding_bin_embedder_unit import pcbe_pkg::*; #(
    parameter int unsigned FRAME_BINS          = FRAME_BINS_DEF,
    parameter int unsigned STEPS_PER_HALF_TURN = STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pcbe_in_if.sink              i_in,
    pcbe_out_if.source           o_out
);

    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    pcbe_front #(
        .FRAME_BINS          (FRAME_BINS),
        .STEPS_PER_HALF_TURN (STEPS_PER_HALF_TURN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    pcbe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_empty    (empty)
    );

    pcbe_back #(
        .FRAME_BINS          (FRAME_BINS),
        .STEPS_PER_HALF_TURN (STEPS_PER_HALF_TURN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/pcbe_front.sv =====
// Front end: accepts bins, tracks frame position and message state, classifies
// each bin and pre-computes the quantizer quotient. Depends on pcbe_pkg, pcbe_in_if.
`default_nettype none

module pcbe_front import pcbe_pkg::*; #(
    parameter int unsigned FRAME_BINS          = FRAME_BINS_DEF,
    parameter int unsigned STEPS_PER_HALF_TURN = STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pcbe_in_if.sink              i_in,
    input  logic                 i_full,
    output logic                 o_push,
    output t_job                 o_job
);

    localparam int unsigned POS_W   = $clog2(FRAME_BINS);
    localparam int unsigned Q_STEP  = PI_UNITS / STEPS_PER_HALF_TURN;
    localparam int unsigned PROD_W  = PHASE_W + RECIP_W;
    localparam logic [POS_W-1:0]   LAST_POS = POS_W'(FRAME_BINS - 1);
    localparam logic [RECIP_W-1:0] RECIP    =
        RECIP_W'(((1 << RECIP_SH) + Q_STEP - 1) / Q_STEP);
    localparam logic [CFG_W-1:0]   COUNT_MAX = '1;

    logic [CFG_W-1:0] r_first_bin;
    logic [CFG_W-1:0] r_end_bin;
    logic [POS_W-1:0] r_pos;
    logic             r_frame_done;
    logic [CFG_W-1:0] r_enc_count;
    logic             r_msg_ended;

    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  lim_x;
    logic              in_embed;
    logic              in_track;
    logic              is_last;
    logic [PHASE_W-1:0] mag;
    logic [PROD_W-1:0]  prod;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        pos_x    = CMP_W'(r_pos);
        lim_x    = CMP_W'(r_first_bin) + CMP_W'(r_enc_count);
        in_embed = (pos_x >= CMP_W'(r_first_bin)) && (pos_x < CMP_W'(r_end_bin))
                   && !r_msg_ended;
        in_track = (pos_x >= CMP_W'(r_first_bin)) && (pos_x < lim_x);
        is_last  = (r_pos == LAST_POS);

        // Floor of |phase| / step by reciprocal; exact for 13-bit magnitudes.
        mag  = i_in.phase_in[PHASE_W-1] ? (~i_in.phase_in + 1'b1) : i_in.phase_in;
        prod = PROD_W'(mag) * PROD_W'(RECIP);

        o_job.phase    = i_in.phase_in;
        o_job.data_bit = i_in.data_bit;
        o_job.quot     = prod[RECIP_SH +: Q_CNT_W];
        o_job.last     = is_last;
        o_job.pos      = POS_MAX_W'(r_pos);
        o_job.taken    = 1'b0;
        o_job.op       = OP_PASS;
        if (!r_frame_done) begin
            if (in_embed && i_in.data_valid) begin
                o_job.op    = OP_QUANT;
                o_job.taken = 1'b1;
            end
        end else if (in_track) begin
            o_job.op = OP_TRACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_bin  <= FIRST_BIN_RST;
            r_end_bin    <= END_BIN_RST;
            r_pos        <= '0;
            r_frame_done <= 1'b0;
            r_enc_count  <= '0;
            r_msg_ended  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FIRST_BIN: r_first_bin <= i_cfg_data;
                    REG_END_BIN:   r_end_bin   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_push) begin
                r_pos <= is_last ? '0 : r_pos + 1'b1;
                if (is_last) begin
                    r_frame_done <= 1'b1;
                end
                if (!r_frame_done && in_embed) begin
                    if (i_in.data_valid) begin
                        if (r_enc_count != COUNT_MAX) begin
                            r_enc_count <= r_enc_count + 1'b1;
                        end
                    end else begin
                        r_msg_ended <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcbe_queue.sv =====
// Short job queue between front and back ends.
// Depends on pcbe_pkg.
`default_nettype none

module pcbe_queue import pcbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_job,
    output logic o_empty
);

    localparam int unsigned DEPTH = QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_job = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcbe_back.sv =====
// Back end: reads the previous-frame phase stores, forms the output phase and
// holds it in the output register. Depends on pcbe_pkg, pcbe_out_if.
`default_nettype none

module pcbe_back import pcbe_pkg::*; #(
    parameter int unsigned FRAME_BINS          = FRAME_BINS_DEF,
    parameter int unsigned STEPS_PER_HALF_TURN = STEPS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job     i_job,
    input  logic     i_empty,
    output logic     o_pop,
    pcbe_out_if.source o_out
);

    localparam int unsigned POS_W    = $clog2(FRAME_BINS);
    localparam int unsigned Q_STEP   = PI_UNITS / STEPS_PER_HALF_TURN;
    localparam int unsigned Q_HALF   = Q_STEP / 2;
    localparam int unsigned ZERO_ONE = (2 * STEPS_PER_HALF_TURN - 1) * Q_HALF;

    logic signed [PHASE_W-1:0] mem_orig [FRAME_BINS];
    logic signed [PHASE_W-1:0] mem_mod  [FRAME_BINS];

    logic                      r_s1_valid;
    t_job                      r_s1_job;
    logic signed [PHASE_W-1:0] r_rd_orig;
    logic signed [PHASE_W-1:0] r_rd_mod;
    logic                      r_out_valid;
    logic signed [PHASE_W-1:0] r_out_phase;
    logic                      r_out_taken;
    logic                      r_out_last;

    logic                      out_load;
    logic                      s1_adv;
    logic [PHASE_W-1:0]        s1_mag;
    logic [WORK_W-1:0]         q_base;
    logic [WORK_W-1:0]         q_mag;
    logic signed [WORK_W-1:0]  q_val;
    logic signed [WORK_W-1:0]  trk_val;
    logic signed [WORK_W-1:0]  raw_val;
    logic signed [WORK_W-1:0]  result;

    assign out_load = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && out_load;
    assign o_pop    = !i_empty && (!r_s1_valid || s1_adv);

    assign o_out.valid     = r_out_valid;
    assign o_out.phase_out = r_out_phase;
    assign o_out.bit_taken = r_out_taken;
    assign o_out.frame_end = r_out_last;

    always_comb begin
        s1_mag = r_s1_job.phase[PHASE_W-1] ? (~r_s1_job.phase + 1'b1) : r_s1_job.phase;
        q_base = WORK_W'(r_s1_job.quot) * WORK_W'(Q_STEP);
        if (r_s1_job.data_bit) begin
            // Outward to the next multiple, unless already on one.
            q_mag = (q_base == WORK_W'(s1_mag)) ? q_base : q_base + WORK_W'(Q_STEP);
        end else begin
            q_mag = q_base + WORK_W'(Q_HALF);
        end
        if (r_s1_job.phase == '0) begin
            q_val = r_s1_job.data_bit ? $signed(WORK_W'(ZERO_ONE)) : $signed(WORK_W'(Q_HALF));
        end else if (r_s1_job.phase[PHASE_W-1]) begin
            q_val = -$signed(q_mag);
        end else begin
            q_val = $signed(q_mag);
        end

        trk_val = WORK_W'(r_rd_mod) + WORK_W'(r_s1_job.phase) - WORK_W'(r_rd_orig);

        case (r_s1_job.op)
            OP_QUANT: raw_val = q_val;
            OP_TRACK: raw_val = trk_val;
            default:  raw_val = WORK_W'(r_s1_job.phase);
        endcase
        // Two steps cover the widest tracking sum.
        result = wrap_step(wrap_step(raw_val));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_job <= i_job;
        end
        if (s1_adv) begin
            r_out_phase <= result[PHASE_W-1:0];
            r_out_taken <= r_s1_job.taken;
            r_out_last  <= r_s1_job.last;
        end
    end

    // Read with the pop, write back when the bin leaves stage one.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_orig <= mem_orig[i_job.pos[POS_W-1:0]];
            r_rd_mod  <= mem_mod[i_job.pos[POS_W-1:0]];
        end
        if (s1_adv) begin
            mem_orig[r_s1_job.pos[POS_W-1:0]] <= r_s1_job.phase;
            mem_mod[r_s1_job.pos[POS_W-1:0]]  <= result[PHASE_W-1:0];
        end
    end

endmodule

`default_nettype wire
